// File: src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and codes for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int ADDR_W  = 48;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;
    localparam int CFG_W   = 1;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_W-1:0] CFG_BASE_ADDRESS   = 1'b1;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SCAN  = 1'b1;

    // per-cell control
    typedef struct packed {
        logic step;     // scan beat accepted this cycle
        logic wr;       // load this cell's pattern entry
        logic active;   // cell lies below the pattern length
    } t_cell_ctl;

endpackage

// File: src/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern entry of the scan chain: holds the entry byte, its wildcard mark
// and one bit of the partial-match vector, fed by its lower neighbor.
// ----------------------------------------------------------------------------
module wbps_cell
    import wbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_value,
    input  logic              i_wild,
    input  logic              i_prev,
    output logic              o_match,
    output logic              o_next
);

    logic [BYTE_W-1:0] r_value;
    logic              r_wild;
    logic              r_match;
    logic              n_match;

    assign n_match = i_ctl.active & i_prev & (r_wild | (r_value == i_byte));
    assign o_next  = n_match;
    assign o_match = r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_value <= i_value;
            r_wild  <= i_wild;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.step) begin
            r_match <= n_match;
        end
    end

endmodule

// File: src/wildcard_byte_pattern_scan_core.sv
// Output: a match address is registered at the edge that accepts the closing
// byte, into the output register or, if it holds an untaken beat, the skid entry.
// Throughput: one beat per cycle while o_in_stall is low; every chain cell
// compares in parallel. A two-entry output register with skid absorbs output
// stall. Reset clears the partial matches, byte offset, registers and output
// stage; pattern entries stay undefined until written.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_core
// Scans a byte stream against a stored pattern with wildcard entries and
// reports the start address of every full match.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_core
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [ADDR_W-1:0]  i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [BYTE_W-1:0]  i_entry_value,
    input  logic               i_entry_wildcard,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_stream_start,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_match_address
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0]       r_len;
    logic [ADDR_W-1:0]      r_base;
    logic [ADDR_W-1:0]      r_offset;
    logic                   r_out_v;
    logic [ADDR_W-1:0]      r_out_addr;
    logic                   r_skid_v;
    logic [ADDR_W-1:0]      r_skid_addr;

    logic                   w_accept;
    logic                   w_scan;
    logic                   w_write;
    logic                   w_take;
    logic [LW-1:0]          w_len_c;
    logic [IW-1:0]          w_sel;
    logic [ADDR_W-1:0]      w_cur_off;
    logic [ADDR_W-1:0]      w_bias;
    logic [ADDR_W-1:0]      w_addr;
    logic                   w_full;
    logic                   w_res_v;
    logic [MAX_PATTERN-1:0] w_match;
    logic [MAX_PATTERN-1:0] w_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_match_address = r_out_addr;

    assign w_accept = i_in_valid & ~r_skid_v;
    assign w_scan   = w_accept & (i_req_type == REQ_SCAN);
    assign w_write  = w_accept & (i_req_type == REQ_WRITE);
    assign w_take   = r_out_v & ~i_out_stall;

    // clamp the length to the chain depth
    always_comb begin
        if (9'(r_len) > 9'(MAX_PATTERN)) begin
            w_len_c = LW'(MAX_PATTERN);
        end else begin
            w_len_c = LW'(r_len);
        end
    end

    assign w_sel     = IW'(w_len_c - LW'(1));
    assign w_cur_off = i_stream_start ? '0 : r_offset;
    assign w_bias    = r_base - ADDR_W'(w_len_c) + ADDR_W'(1);
    assign w_addr    = w_bias + w_cur_off;
    assign w_full    = (w_len_c != '0) & w_next[w_sel];
    assign w_res_v   = w_scan & w_full;

    // cell chain
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_cell_ctl w_ctl;
        logic      w_prev;

        assign w_ctl.step   = w_scan;
        assign w_ctl.wr     = w_write & (9'(i_entry_index) == 9'(k));
        assign w_ctl.active = LW'(k) < w_len_c;

        if (k == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = ~i_stream_start & w_match[k-1];
        end

        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_byte  (i_data_byte),
            .i_value (i_entry_value),
            .i_wild  (i_entry_wildcard),
            .i_prev  (w_prev),
            .o_match (w_match[k]),
            .o_next  (w_next[k])
        );
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_base <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_BASE_ADDRESS:   r_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offset of the next scanned byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (w_scan) begin
            r_offset <= w_cur_off + ADDR_W'(1);
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_res_v) begin
            if (r_out_v & ~w_take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_addr <= r_skid_addr;
            end
        end else if (w_res_v) begin
            if (r_out_v & ~w_take) begin
                r_skid_addr <= w_addr;
            end else begin
                r_out_addr <= w_addr;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // skid entry only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid with empty output register");

    // a result needs a scan beat and a nonzero pattern length
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_v |-> (w_scan && (w_len_c != '0)))
        else $error("result without scan beat or with zero length");

    // region start restarts the offset
    a_start_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scan && i_stream_start) |=> (r_offset == ADDR_W'(1)))
        else $error("offset not restarted at region start");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wildcard_byte_pattern_scan_core. Pattern entries and
// scan bytes are queued by a stimulus process, driven by a clocked driver that
// predicts each accepted beat, and match addresses are checked in order by a
// clocked monitor. The input idles and the output stalls in random bursts.
// ----------------------------------------------------------------------------
module tb;
    import wbps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int MAX_ENTRIES = 64;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic               req_type;
        logic [INDEX_W-1:0] entry_index;
        logic [BYTE_W-1:0]  entry_value;
        logic               entry_wildcard;
        logic [BYTE_W-1:0]  data_byte;
        logic               stream_start;
    } t_scan_req;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_index      = CFG_PATTERN_LENGTH;
    logic [ADDR_W-1:0]  i_cfg_data       = '0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic               i_req_type       = REQ_WRITE;
    logic [INDEX_W-1:0] i_entry_index    = '0;
    logic [BYTE_W-1:0]  i_entry_value    = '0;
    logic               i_entry_wildcard = 1'b0;
    logic [BYTE_W-1:0]  i_data_byte      = '0;
    logic               i_stream_start   = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic [ADDR_W-1:0]  o_match_address;

    // pending beats and expected match addresses
    t_scan_req         req_q[$];
    t_scan_req         req_on_bus;
    logic [ADDR_W-1:0] expected_addr_q[$];

    // predictor state, updated as beats and register writes are accepted
    logic [BYTE_W-1:0]  pat_value [MAX_ENTRIES];
    logic               pat_wild  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] partial_hits = '0;
    logic [ADDR_W-1:0]  scan_offset  = '0;
    logic [LEN_W-1:0]   length_reg   = '0;
    logic [ADDR_W-1:0]  base_reg     = '0;

    // stimulus-side view of the pattern, used to build matching runs
    logic [BYTE_W-1:0]  gen_value   [MAX_ENTRIES];
    logic               gen_wild    [MAX_ENTRIES];
    logic               gen_written [MAX_ENTRIES];

    int  items_queued     = 0;
    int  items_accepted   = 0;
    int  results_expected = 0;
    int  results_seen     = 0;
    int  fail_count       = 0;
    int  idle_cycles      = 0;
    int  in_gap           = 0;
    int  out_burst        = 0;
    bit  calm             = 1'b0;

    wildcard_byte_pattern_scan_core #(
        .MAX_PATTERN (MAX_ENTRIES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_entry_wildcard (i_entry_wildcard),
        .i_data_byte      (i_data_byte),
        .i_stream_start   (i_stream_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_address  (o_match_address)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
        $display("MISMATCH @%0t: %s: got %012h, want %012h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Advance the predictor by one accepted beat.
    task automatic apply_request(input t_scan_req req);
        int                     n;
        logic                   prev;
        logic                   hit;
        logic [MAX_ENTRIES-1:0] next_hits;
        logic [ADDR_W-1:0]      addr;
        if (req.req_type == REQ_WRITE) begin
            pat_value[req.entry_index] = req.entry_value;
            pat_wild[req.entry_index]  = req.entry_wildcard;
            return;
        end
        if (req.stream_start) begin
            partial_hits = '0;
            scan_offset  = '0;
        end
        n = (length_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(length_reg);
        next_hits = '0;
        for (int k = 0; k < n; k++) begin
            hit  = pat_wild[k] || (pat_value[k] == req.data_byte);
            prev = (k == 0) ? 1'b1 : partial_hits[k-1];
            next_hits[k] = prev && hit;
        end
        partial_hits = next_hits;
        if (n > 0 && partial_hits[n-1]) begin
            addr = base_reg + scan_offset - ADDR_W'(n - 1);
            expected_addr_q.insert(expected_addr_q.size(), addr);
            results_expected <= results_expected + 1;
        end
        scan_offset = scan_offset + 1'b1;
    endtask

    // Driver: hold a stalled beat, otherwise advance to the next one or a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_request(req_on_bus);
                items_accepted <= items_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    req_on_bus = req_q.pop_front();
                    i_req_type       <= req_on_bus.req_type;
                    i_entry_index    <= req_on_bus.entry_index;
                    i_entry_value    <= req_on_bus.entry_value;
                    i_entry_wildcard <= req_on_bus.entry_wildcard;
                    i_data_byte      <= req_on_bus.data_byte;
                    i_stream_start   <= req_on_bus.stream_start;
                    i_in_valid       <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted match address, then pick the next stall.
    always @(posedge i_clk) begin
        logic [ADDR_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_addr_q.size() == 0) begin
                    flag_mismatch("match with none expected", o_match_address, '0);
                end else begin
                    want = expected_addr_q.pop_front();
                    results_seen <= results_seen + 1;
                    if (o_match_address !== want)
                        flag_mismatch("match_address", o_match_address, want);
                end
            end
            if (calm) begin
                out_burst = 0;
                i_out_stall <= 1'b0;
            end else if (out_burst > 0) begin
                out_burst--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                out_burst = $urandom_range(1, 17) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("wildcard_byte_pattern_scan_core verification failed");
            $finish;
        end
    end

    task automatic push_write(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] value,
                              input logic wild);
        t_scan_req req;
        req.req_type       = REQ_WRITE;
        req.entry_index    = idx;
        req.entry_value    = value;
        req.entry_wildcard = wild;
        req.data_byte      = BYTE_W'($urandom);
        req.stream_start   = 1'($urandom);
        req_q.insert(req_q.size(), req);
        items_queued++;
        gen_value[idx]   = value;
        gen_wild[idx]    = wild;
        gen_written[idx] = 1'b1;
    endtask

    task automatic push_scan(input logic [BYTE_W-1:0] value, input logic first);
        t_scan_req req;
        req.req_type       = REQ_SCAN;
        req.entry_index    = INDEX_W'($urandom);
        req.entry_value    = BYTE_W'($urandom);
        req.entry_wildcard = 1'($urandom);
        req.data_byte      = value;
        req.stream_start   = first;
        req_q.insert(req_q.size(), req);
        items_queued++;
    endtask

    // Mostly a few recurring values, so that runs overlap and noise hits.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PATTERN_LENGTH)
            length_reg = data[LEN_W-1:0];
        else
            base_reg = data;
    endtask

    // Wait until every queued beat is taken and every match has come back.
    task automatic settle();
        while (items_accepted != items_queued || results_seen != results_expected)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] base,
                             input int budget);
        int n;
        int first_item;
        int pick;
        int flip_at;
        logic [BYTE_W-1:0] b;
        settle();
        write_reg(CFG_PATTERN_LENGTH, ADDR_W'(len));
        write_reg(CFG_BASE_ADDRESS, base);
        n = (len > MAX_ENTRIES) ? MAX_ENTRIES : int'(len);
        // never scan against an entry that has not been loaded
        for (int k = 0; k < n; k++)
            if (!gen_written[k])
                push_write(INDEX_W'(k), pick_byte(), $urandom_range(0, 3) == 0);
        first_item = items_queued;
        while (items_queued - first_item < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && n > 0) begin
                flip_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
                for (int k = 0; k < n; k++) begin
                    b = gen_wild[k] ? BYTE_W'($urandom) : gen_value[k];
                    if (k == flip_at)
                        b = b ^ (8'h01 << $urandom_range(0, 7));
                    push_scan(b, k == 0 && $urandom_range(0, 7) == 0);
                end
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 6)) push_scan(pick_byte(), 1'b0);
            end else if (pick < 86) begin
                push_scan(pick_byte(), 1'b1);
            end else if (n > 0 && pick < 93) begin
                // rewrite an active entry mid-stream
                push_write(INDEX_W'($urandom_range(0, n - 1)), pick_byte(),
                           $urandom_range(0, 3) == 0);
            end else begin
                push_write(INDEX_W'($urandom), pick_byte(), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            pat_value[k]   = '0;
            pat_wild[k]    = 1'b0;
            gen_value[k]   = '0;
            gen_wild[k]    = 1'b0;
            gen_written[k] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length: bytes scan but nothing can match
        push_scan(8'h00, 1'b1);
        push_scan(8'hFF, 1'b0);
        push_write(6'd0, 8'h00, 1'b0);
        push_write(6'd1, 8'hFF, 1'b1);
        push_write(6'd2, 8'h7E, 1'b0);
        push_write(6'd63, 8'hFF, 1'b0);
        settle();
        write_reg(CFG_PATTERN_LENGTH, ADDR_W'(2));
        write_reg(CFG_BASE_ADDRESS, '0);
        push_scan(8'h00, 1'b1);
        push_scan(8'h33, 1'b0);
        push_scan(8'h00, 1'b0);
        push_scan(8'h00, 1'b0);
        push_scan(8'hFF, 1'b0);
        // top base address: start addresses wrap
        settle();
        write_reg(CFG_PATTERN_LENGTH, ADDR_W'(3));
        write_reg(CFG_BASE_ADDRESS, '1);
        push_scan(8'h00, 1'b1);
        push_scan(8'hAB, 1'b0);
        push_scan(8'h7E, 1'b0);
        push_scan(8'h00, 1'b0);
        push_scan(8'h01, 1'b0);
        push_scan(8'h7E, 1'b0);
        // shrink the length mid-stream, no new region
        settle();
        write_reg(CFG_PATTERN_LENGTH, ADDR_W'(1));
        push_scan(8'h00, 1'b0);
        push_scan(8'h7E, 1'b0);

        run_phase(7'd1, ADDR_W'({$urandom, $urandom}), 50);
        run_phase(7'd4, '0, 60);
        run_phase(7'd64, ADDR_W'({$urandom, $urandom}), 100);
        run_phase(7'd2, ADDR_W'({$urandom, $urandom}), 50);
        run_phase(7'd127, '1, 100);
        run_phase(7'd0, ADDR_W'({$urandom, $urandom}), 30);
        run_phase(7'd6, ADDR_W'({$urandom, $urandom}), 60);
        calm = 1'b1;
        run_phase(7'd3, ADDR_W'({$urandom, $urandom}), 60);

        settle();
        repeat (8) @(posedge i_clk);
        if (expected_addr_q.size() != 0)
            flag_mismatch("expected match never came", '0, expected_addr_q[0]);
        if (fail_count == 0)
            $display("wildcard_byte_pattern_scan_core verification clean");
        else
            $display("wildcard_byte_pattern_scan_core verification failed");
        $finish;
    end

endmodule
